@@ rtl/fcfl_pkg.sv @@
package fcfl_pkg;

  // Input operation codes (s_axis_tuser)
  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_REBUILD = 2'd2
  } fcfl_op_e;

  // Result status codes (m_axis_tuser)
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2
  } fcfl_status_e;

  // Configuration register indexes
  localparam logic [1:0] CFG_BASE  = 2'd0;
  localparam logic [1:0] CFG_BYTES = 2'd1;
  localparam logic [1:0] CFG_COUNT = 2'd2;

  localparam int unsigned CfgW       = 32;
  localparam int unsigned BytesW     = 17;
  localparam int unsigned CountW     = 11;
  localparam int unsigned PortIdxW   = 10;
  localparam int unsigned AddrW      = 32;
  localparam int unsigned MinBytes   = 8;
  localparam int unsigned InDataW    = 16;
  localparam int unsigned OutDataW   = 48;

endpackage

@@ rtl/fcfl_ram.sv @@
module fcfl_ram #(
  parameter int unsigned WIDTH = 11,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/fcfl_addr.sv @@
module fcfl_addr #(
  parameter int unsigned LINK_W = 11
) (
  input  logic                        clk_i,
  input  logic                        load_i,
  input  logic [LINK_W-1:0]           index_i,
  input  logic [fcfl_pkg::BytesW-1:0] bytes_i,
  input  logic [fcfl_pkg::AddrW-1:0]  base_i,
  output logic [fcfl_pkg::AddrW-1:0]  addr_o
);
  import fcfl_pkg::*;

  localparam int unsigned ProdW = LINK_W + BytesW;

  logic [ProdW-1:0] prod_full;
  logic [AddrW-1:0] prod_d, prod_q;

  // Chunk sizes below the minimum act as the minimum
  logic [BytesW-1:0] eff_bytes;
  assign eff_bytes = (bytes_i < BytesW'(MinBytes)) ? BytesW'(MinBytes) : bytes_i;

  assign prod_full = ProdW'(index_i) * ProdW'(eff_bytes);
  assign prod_d    = AddrW'(prod_full);

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prod_q <= prod_d;
    end
  end

  // Wrap to 32 bits
  assign addr_o = base_i + prod_q;

endmodule

@@ rtl/fixed_chunk_free_list_allocator_top.sv @@
// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata: has_chunk, chunk_index; tuser: operation
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: granted, index, address; tuser: status
// cfg       in   cfg_we_i                      cfg_idx_i, cfg_data_i
//
// Release, null release, empty allocate and unknown codes register their result from S_IDLE.
// A granted allocate passes through S_ALLOC: the head's link is read from the link RAM.
// Rebuild makes one link RAM write per chunk in S_BUILD; a zero count only empties the list.
// One item is in flight at a time; a new beat is taken while the result register
// drains in the same cycle. Reset empties the free list; link RAM is not cleared.
module fixed_chunk_free_list_allocator_top #(
  parameter int unsigned MAX_CHUNKS = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // fields from bit 0: has_chunk[0], chunk_index[10:1], zero pad
  input  logic [fcfl_pkg::InDataW-1:0]   s_axis_tdata,
  // fields from bit 0: operation[1:0]
  input  logic [1:0]                     s_axis_tuser,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // fields from bit 0: granted[0], given_index[10:1], given_address[42:11], zero pad
  output logic [fcfl_pkg::OutDataW-1:0]  m_axis_tdata,
  // fields from bit 0: status[1:0]
  output logic [1:0]                     m_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic                           cfg_we_i,
  input  logic [1:0]                     cfg_idx_i,
  input  logic [fcfl_pkg::CfgW-1:0]      cfg_data_i
);
  import fcfl_pkg::*;

  localparam int unsigned LinkW = $clog2(MAX_CHUNKS + 1);
  localparam int unsigned IdxW  = $clog2(MAX_CHUNKS);
  localparam logic [LinkW-1:0] NullLink = LinkW'(MAX_CHUNKS);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_ALLOC = 3'b010,
    S_BUILD = 3'b100
  } state_e;

  state_e state_d, state_q;

  logic [AddrW-1:0]  base_q;
  logic [BytesW-1:0] bytes_q;
  logic [CountW-1:0] count_q;

  logic [LinkW-1:0] head_d, head_q;
  logic [LinkW-1:0] sweep_d, sweep_q;
  logic [LinkW-1:0] alloc_idx_d, alloc_idx_q;

  logic             out_valid_d, out_valid_q;
  logic             out_granted_d, out_granted_q;
  logic [PortIdxW-1:0] out_index_d, out_index_q;
  logic [AddrW-1:0] out_addr_d, out_addr_q;
  fcfl_status_e     out_status_d, out_status_q;

  logic             ram_we, ram_re;
  logic [IdxW-1:0]  ram_waddr, ram_raddr;
  logic [LinkW-1:0] ram_wdata, ram_rdata;
  logic             addr_load;
  logic [AddrW-1:0] alloc_addr;

  logic [31:0]      count32, eff_count32, idx32, head32;
  logic [LinkW-1:0] eff_count;
  logic             in_fire, out_fire, head_empty, last_step;
  logic             in_has;
  logic [PortIdxW-1:0] in_index;
  fcfl_op_e         in_op;

  assign in_has   = s_axis_tdata[0];
  assign in_index = s_axis_tdata[PortIdxW:1];
  assign in_op    = fcfl_op_e'(s_axis_tuser);

  assign count32     = 32'(count_q);
  assign eff_count32 = (count32 > 32'(MAX_CHUNKS)) ? 32'(MAX_CHUNKS) : count32;
  assign eff_count   = LinkW'(eff_count32);
  assign idx32       = 32'(in_index);
  assign head32      = 32'(head_q);
  assign head_empty  = (head32 >= 32'(MAX_CHUNKS));
  assign last_step   = ((sweep_q + LinkW'(1)) == eff_count);

  assign out_fire      = out_valid_q & m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE) & (~out_valid_q | m_axis_tready);
  assign in_fire       = s_axis_tvalid & s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      bytes_q <= BytesW'(MinBytes);
      count_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BASE:  base_q  <= cfg_data_i;
        CFG_BYTES: bytes_q <= cfg_data_i[BytesW-1:0];
        CFG_COUNT: count_q <= cfg_data_i[CountW-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    state_d       = state_q;
    head_d        = head_q;
    sweep_d       = sweep_q;
    alloc_idx_d   = alloc_idx_q;
    out_valid_d   = out_valid_q & ~out_fire;
    out_granted_d = out_granted_q;
    out_index_d   = out_index_q;
    out_addr_d    = out_addr_q;
    out_status_d  = out_status_q;
    ram_we        = 1'b0;
    ram_waddr     = sweep_q[IdxW-1:0];
    ram_wdata     = head_q;
    ram_re        = 1'b0;
    ram_raddr     = head_q[IdxW-1:0];
    addr_load     = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          // default result: nothing granted, status ok
          out_granted_d = 1'b0;
          out_index_d   = '0;
          out_addr_d    = '0;
          out_status_d  = ST_OK;
          case (in_op)
            OP_ALLOC: begin
              if (head_empty) begin
                out_status_d = ST_EMPTY;
                out_valid_d  = 1'b1;
              end else begin
                ram_re      = 1'b1;
                addr_load   = 1'b1;
                alloc_idx_d = head_q;
                state_d     = S_ALLOC;
              end
            end
            OP_RELEASE: begin
              out_valid_d = 1'b1;
              if (in_has) begin
                if (idx32 >= eff_count32) begin
                  out_status_d = ST_RANGE;
                end else begin
                  ram_we    = 1'b1;
                  ram_waddr = IdxW'(in_index);
                  ram_wdata = head_q;
                  head_d    = LinkW'(in_index);
                end
              end
            end
            OP_REBUILD: begin
              if (eff_count == '0) begin
                head_d      = NullLink;
                out_valid_d = 1'b1;
              end else begin
                sweep_d = '0;
                state_d = S_BUILD;
              end
            end
            default: begin
              out_valid_d = 1'b1;
            end
          endcase
        end
      end
      S_ALLOC: begin
        // pop: link of the old head becomes the new head
        head_d        = ram_rdata;
        out_granted_d = 1'b1;
        out_index_d   = PortIdxW'(32'(alloc_idx_q));
        out_addr_d    = alloc_addr;
        out_status_d  = ST_OK;
        out_valid_d   = 1'b1;
        state_d       = S_IDLE;
      end
      S_BUILD: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_q[IdxW-1:0];
        ram_wdata = last_step ? NullLink : (sweep_q + LinkW'(1));
        sweep_d   = sweep_q + LinkW'(1);
        if (last_step) begin
          head_d      = '0;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= NullLink;
      sweep_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      sweep_q     <= sweep_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    alloc_idx_q   <= alloc_idx_d;
    out_granted_q <= out_granted_d;
    out_index_q   <= out_index_d;
    out_addr_q    <= out_addr_d;
    out_status_q  <= out_status_d;
  end

  fcfl_ram #(
    .WIDTH (LinkW),
    .DEPTH (MAX_CHUNKS)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  fcfl_addr #(
    .LINK_W (LinkW)
  ) u_addr (
    .clk_i   (clk_i),
    .load_i  (addr_load),
    .index_i (head_q),
    .bytes_i (bytes_q),
    .base_i  (base_q),
    .addr_o  (alloc_addr)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {
    (OutDataW - AddrW - PortIdxW - 1)'(0), out_addr_q, out_index_q, out_granted_q
  };

endmodule

@@ rtl/fcfl_checker.sv @@
module fcfl_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [1:0]                     s_axis_tuser,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  input  logic [fcfl_pkg::OutDataW-1:0]  m_axis_tdata,
  input  logic [1:0]                     m_axis_tuser,
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready
);
  import fcfl_pkg::*;

  logic in_fire;
  assign in_fire = s_axis_tvalid & s_axis_tready;

  // a waiting result beat stays until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat dropped before taken");

  a_grant_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tuser == ST_OK)
    else $error("granted beat with non-ok status");

  a_nogrant_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[42:1] == '0)
    else $error("index or address nonzero without grant");

  // release and unknown operations show their result on the next cycle
  a_fast_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && s_axis_tuser != OP_ALLOC && s_axis_tuser != OP_REBUILD |=> m_axis_tvalid)
    else $error("release result missing");

endmodule

bind fixed_chunk_free_list_allocator_top fcfl_checker u_fcfl_checker (.*);

@@ dv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import fcfl_pkg::*;

  localparam int unsigned PoolSlots  = 1024;
  localparam int unsigned CycleLimit = 600000;
  localparam logic [1:0]  OpUnused   = 2'd3;

  typedef struct packed {
    logic         granted;
    logic [9:0]   index;
    logic [31:0]  address;
    fcfl_status_e status;
  } pool_result_t;

  typedef struct {
    bit           is_reg;
    logic [1:0]   code;
    logic         has;
    logic [9:0]   idx;
    logic [31:0]  value;
    bit           typed;
    pool_result_t result;
  } plan_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic [InDataW-1:0]    s_axis_tdata = '0;
  logic [1:0]            s_axis_tuser = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [OutDataW-1:0]   m_axis_tdata;
  logic [1:0]            m_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [1:0]            cfg_idx_i = '0;
  logic [CfgW-1:0]       cfg_data_i = '0;

  // shadow of the pool
  logic [31:0]  pool_base = '0;
  logic [16:0]  pool_bytes = 17'(MinBytes);
  logic [10:0]  pool_count = '0;
  logic [10:0]  link_mem [PoolSlots];
  logic [10:0]  free_head = 11'(PoolSlots);
  logic [9:0]   granted_chunks [$];

  pool_result_t expected_results [$];
  plan_row_t    directed_plan [$];

  int  errors = 0;
  int  cycle_count = 0;
  int  send_idle = 25;
  int  recv_idle = 54;
  bit  hold_armed = 1'b0;
  logic rx_hold = 1'b0;

  fixed_chunk_free_list_allocator_top #(
    .MAX_CHUNKS(PoolSlots)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic pool_result_t predict_pool_result(logic [1:0] op, logic has,
                                                       logic [9:0] idx);
    pool_result_t r;
    logic [10:0]  live_count;
    logic [16:0]  step_bytes;
    logic [31:0]  offset;
    int           hits [$];
    r = '{granted: 1'b0, index: '0, address: '0, status: ST_OK};
    live_count = (pool_count > 11'(PoolSlots)) ? 11'(PoolSlots) : pool_count;
    step_bytes = (pool_bytes < 17'(MinBytes)) ? 17'(MinBytes) : pool_bytes;
    case (op)
      OP_ALLOC: begin
        if (free_head >= 11'(PoolSlots)) begin
          r.status = ST_EMPTY;
        end else begin
          offset = 32'(free_head) * 32'(step_bytes);
          r.granted = 1'b1;
          r.index = free_head[9:0];
          r.address = pool_base + offset;
          granted_chunks.push_back(free_head[9:0]);
          free_head = link_mem[free_head[9:0]];
        end
      end
      OP_RELEASE: begin
        if (has) begin
          if ({1'b0, idx} >= live_count) begin
            r.status = ST_RANGE;
          end else begin
            link_mem[idx] = free_head;
            free_head = {1'b0, idx};
            hits = granted_chunks.find_first_index(x) with (x == idx);
            if (hits.size() != 0) granted_chunks.delete(hits[0]);
          end
        end
      end
      OP_REBUILD: begin
        if (live_count == 0) begin
          free_head = 11'(PoolSlots);
        end else begin
          for (int i = 0; i < int'(live_count) - 1; i++) link_mem[i] = 11'(i + 1);
          link_mem[live_count - 1] = 11'(PoolSlots);
          free_head = '0;
        end
        granted_chunks.delete();
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic plan_beat(input logic [1:0] op, input logic has, input logic [9:0] idx,
                           input bit typed, input logic g, input logic [9:0] gi,
                           input logic [31:0] ga, input fcfl_status_e st);
    plan_row_t row;
    row.is_reg = 1'b0;
    row.code = op;
    row.has = has;
    row.idx = idx;
    row.value = '0;
    row.typed = typed;
    row.result = '{granted: g, index: gi, address: ga, status: st};
    directed_plan.push_back(row);
  endtask

  task automatic plan_reg(input logic [1:0] ridx, input logic [31:0] value);
    plan_row_t row;
    row.is_reg = 1'b1;
    row.code = ridx;
    row.has = 1'b0;
    row.idx = '0;
    row.value = value;
    row.typed = 1'b0;
    row.result = '0;
    directed_plan.push_back(row);
  endtask

  // called at a rising edge; returns at the edge where the beat is taken
  task automatic send_beat(input logic [1:0] op, input logic has, input logic [9:0] idx,
                           input bit typed, input pool_result_t typed_result);
    pool_result_t predicted;
    if ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    s_axis_tdata <= {5'b0, idx, has};
    s_axis_tuser <= op;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predicted = predict_pool_result(op, has, idx);
    expected_results.push_back(typed ? typed_result : predicted);
  endtask

  // drop valid and drain every outstanding result
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] ridx, input logic [31:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= ridx;
    cfg_data_i <= value;
    case (ridx)
      CFG_BASE:  pool_base = value;
      CFG_BYTES: pool_bytes = value[16:0];
      CFG_COUNT: pool_count = value[10:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    m_axis_tready <= !rx_hold && ($urandom_range(99) >= recv_idle);
  end

  // long receiver stall so the block backs up into its input
  initial begin
    wait (hold_armed);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (400) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  always @(posedge clk_i) begin : result_check
    pool_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual tdata %h tuser %h",
                 $time, m_axis_tdata, m_axis_tuser);
        errors++;
      end else begin
        want = expected_results.pop_front();
        check_field("granted", 32'(want.granted), 32'(m_axis_tdata[0]));
        check_field("given_index", 32'(want.index), 32'(m_axis_tdata[10:1]));
        check_field("given_address", want.address, m_axis_tdata[42:11]);
        check_field("status", 32'(want.status), 32'(m_axis_tuser));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    logic [1:0]  op;
    logic        has;
    logic [9:0]  idx;
    logic [31:0] value;
    int          pick;
    foreach (link_mem[i]) link_mem[i] = '0;

    // empty pool after reset, then extremes, stale count, double release
    plan_beat(OP_ALLOC, 1'b0, 10'd0, 1'b1, 1'b0, 10'd0, 32'd0, ST_EMPTY);
    plan_beat(OP_RELEASE, 1'b1, 10'd0, 1'b1, 1'b0, 10'd0, 32'd0, ST_RANGE);
    plan_beat(OP_RELEASE, 1'b0, 10'h3FF, 1'b1, 1'b0, 10'd0, 32'd0, ST_OK);
    plan_beat(OpUnused, 1'b1, 10'h3FF, 1'b1, 1'b0, 10'd0, 32'd0, ST_OK);
    plan_beat(OP_REBUILD, 1'b0, 10'd0, 1'b1, 1'b0, 10'd0, 32'd0, ST_OK);
    plan_beat(OP_ALLOC, 1'b0, 10'd0, 1'b1, 1'b0, 10'd0, 32'd0, ST_EMPTY);
    plan_reg(CFG_BASE, 32'hFFFF_FFFF);
    plan_reg(CFG_BYTES, 32'd65536);
    plan_reg(CFG_COUNT, 32'd1024);
    plan_beat(OP_REBUILD, 1'b1, 10'h3FF, 1'b1, 1'b0, 10'd0, 32'd0, ST_OK);
    plan_beat(OP_ALLOC, 1'b0, 10'd0, 1'b1, 1'b1, 10'd0, 32'hFFFF_FFFF, ST_OK);
    plan_beat(OP_ALLOC, 1'b0, 10'd0, 1'b1, 1'b1, 10'd1, 32'h0000_FFFF, ST_OK);
    plan_beat(OP_RELEASE, 1'b1, 10'h3FF, 1'b1, 1'b0, 10'd0, 32'd0, ST_OK);
    plan_beat(OP_ALLOC, 1'b0, 10'd0, 1'b1, 1'b1, 10'h3FF, 32'h03FE_FFFF, ST_OK);
    plan_reg(CFG_COUNT, 32'd3);
    plan_beat(OP_ALLOC, 1'b0, 10'd0, 1'b1, 1'b1, 10'd2, 32'h0001_FFFF, ST_OK);
    plan_beat(OP_ALLOC, 1'b0, 10'd0, 1'b1, 1'b1, 10'd3, 32'h0002_FFFF, ST_OK);
    plan_beat(OP_RELEASE, 1'b1, 10'd3, 1'b1, 1'b0, 10'd0, 32'd0, ST_RANGE);
    plan_beat(OP_RELEASE, 1'b1, 10'd0, 1'b0, 1'b0, 10'd0, 32'd0, ST_OK);
    plan_beat(OP_RELEASE, 1'b1, 10'd0, 1'b0, 1'b0, 10'd0, 32'd0, ST_OK);
    plan_beat(OP_ALLOC, 1'b0, 10'd0, 1'b0, 1'b0, 10'd0, 32'd0, ST_OK);
    plan_beat(OP_ALLOC, 1'b0, 10'd0, 1'b0, 1'b0, 10'd0, 32'd0, ST_OK);
    plan_reg(CFG_BASE, 32'h0000_1000);
    plan_reg(CFG_BYTES, 32'd8);
    plan_beat(OP_REBUILD, 1'b0, 10'd0, 1'b1, 1'b0, 10'd0, 32'd0, ST_OK);
    plan_beat(OP_ALLOC, 1'b0, 10'd0, 1'b1, 1'b1, 10'd0, 32'h0000_1000, ST_OK);
    plan_beat(OP_ALLOC, 1'b0, 10'd0, 1'b1, 1'b1, 10'd1, 32'h0000_1008, ST_OK);
    plan_beat(OP_ALLOC, 1'b0, 10'd0, 1'b1, 1'b1, 10'd2, 32'h0000_1010, ST_OK);
    plan_beat(OP_ALLOC, 1'b0, 10'd0, 1'b1, 1'b0, 10'd0, 32'd0, ST_EMPTY);
    plan_beat(OpUnused, 1'b0, 10'd0, 1'b1, 1'b0, 10'd0, 32'd0, ST_OK);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (directed_plan[n]) begin
      if (directed_plan[n].is_reg) begin
        wait_idle();
        write_reg(directed_plan[n].code, directed_plan[n].value);
      end else begin
        send_beat(directed_plan[n].code, directed_plan[n].has, directed_plan[n].idx,
                  directed_plan[n].typed, directed_plan[n].result);
      end
    end

    for (int mode = 0; mode < 3; mode++) begin
      send_idle = (mode == 0) ? 25 : (mode == 1) ? 54 : 0;
      recv_idle = (mode == 0) ? 54 : (mode == 1) ? 25 : 0;
      for (int phase = 0; phase < 11; phase++) begin
        wait_idle();
        pick = $urandom_range(3);
        value = (pick == 0) ? 32'd0 : (pick == 1) ? 32'hFFFF_FFFF : $urandom;
        write_reg(CFG_BASE, value);
        pick = $urandom_range(3);
        value = (pick == 0) ? 32'd8 : (pick == 1) ? 32'd65536 :
                (pick == 2) ? 32'($urandom_range(65536, 8)) : 32'($urandom_range(64, 8));
        write_reg(CFG_BYTES, value);
        // keep most pools small so rebuild walks stay short
        pick = $urandom_range(9);
        value = (pick == 0) ? 32'd0 : (pick == 1) ? 32'd1024 :
                (pick == 2) ? 32'($urandom_range(1024)) : 32'($urandom_range(24, 1));
        write_reg(CFG_COUNT, value);
        if (mode == 0 && phase == 3) hold_armed = 1'b1;
        if ($urandom_range(4) != 0) send_beat(OP_REBUILD, 1'b0, 10'd0, 1'b0, '0);
        for (int k = 0; k < 33; k++) begin
          pick = $urandom_range(99);
          op = (pick < 46) ? OP_ALLOC : (pick < 88) ? OP_RELEASE :
               (pick < 94) ? OP_REBUILD : OpUnused;
          has = ($urandom_range(9) != 0);
          pick = $urandom_range(9);
          if (op == OP_RELEASE && has && granted_chunks.size() != 0 && pick < 7)
            idx = granted_chunks[$urandom_range(granted_chunks.size() - 1)];
          else if (pick < 8)
            idx = 10'(int'(pool_count) + int'($urandom_range(2)) - 1);
          else
            idx = 10'($urandom_range(1023));
          send_beat(op, has, idx, 1'b0, '0);
        end
      end
    end

    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
